### rtl/pdfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdfl_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int DEPTH_BITS_DEF  = 16;
    localparam int RANGE_BITS      = 32;

    // Character codes the lexer looks for.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_O      = 8'h4F;

    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_COMMENT = 8'b0000_0010,
        MODE_LITERAL = 8'b0000_0100,
        MODE_ESCAPE  = 8'b0000_1000,
        MODE_HEXPEND = 8'b0001_0000,
        MODE_HEX     = 8'b0010_0000,
        MODE_NAME    = 8'b0100_0000,
        MODE_REGULAR = 8'b1000_0000
    } t_mode;

    typedef enum logic [3:0] {
        TM_NONE, TM_SL, TM_SL_O, TM_SL_OC, TM_NAME_OTHER,
        TM_B, TM_BD, TM_BDC, TM_E, TM_EM, TM_EMC, TM_OTHER
    } t_match;

    typedef enum logic [1:0] {
        TC_NONE, TC_OC, TC_NAME, TC_OTHER
    } t_class;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [RANGE_BITS-1:0] range_start;
        logic [RANGE_BITS-1:0] range_end;
        logic                  opens_section;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_lex_out;

    function automatic logic f_is_ws(input logic [7:0] c);
        f_is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic f_is_separator(input logic [7:0] c);
        f_is_separator = f_is_ws(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_LT ||
                         c == CH_GT || c == CH_LBRACK || c == CH_RBRACK ||
                         c == CH_LBRACE || c == CH_RBRACE || c == CH_SLASH || c == CH_PCT;
    endfunction

endpackage

`default_nettype wire

### rtl/pdfl_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

module pdfl_lexer
    import pdfl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in      i_in,
    output t_lex_out      o_lex
);

    typedef struct packed {
        t_mode                  mode;
        logic [DEPTH_BITS-1:0]  depth;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] tbegin;
        t_match                 match;
        logic [OFFSET_BITS-1:0] pbegin;
        t_class                 pclass;
        logic [OFFSET_BITS-1:0] obegin;
        t_class                 oclass;
    } t_st;

    localparam t_st ST_RESET = '{
        mode:   MODE_IDLE,
        depth:  '0,
        pos:    '0,
        tbegin: '0,
        match:  TM_NONE,
        pbegin: '0,
        pclass: TC_NONE,
        obegin: '0,
        oclass: TC_NONE
    };

    t_st      r_st;
    t_st      n_st;
    t_lex_out lex;

    function automatic logic [OFFSET_BITS-1:0] f_sat_inc(input logic [OFFSET_BITS-1:0] v);
        f_sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    // Result of closing the current token at end offset end_off, if any.
    function automatic t_lex_out f_emit(input t_st s, input logic [OFFSET_BITS-1:0] end_off);
        t_lex_out r;
        r = '0;
        if (s.match == TM_BDC && s.oclass == TC_OC &&
                (s.pclass == TC_OC || s.pclass == TC_NAME)) begin
            r.valid             = 1'b1;
            r.res.range_start   = RANGE_BITS'(s.obegin);
            r.res.range_end     = RANGE_BITS'(end_off);
            r.res.opens_section = 1'b1;
        end else if (s.match == TM_EMC) begin
            r.valid             = 1'b1;
            r.res.range_start   = RANGE_BITS'(s.tbegin);
            r.res.range_end     = RANGE_BITS'(end_off);
            r.res.opens_section = 1'b0;
        end
        f_emit = r;
    endfunction

    // Shifts the closed token into the two-token history.
    function automatic t_st f_finish(input t_st s);
        t_st    r;
        t_class cls;
        r = s;
        if (s.match == TM_SL_OC) begin
            cls = TC_OC;
        end else if (s.match == TM_SL || s.match == TM_SL_O || s.match == TM_NAME_OTHER) begin
            cls = TC_NAME;
        end else begin
            cls = TC_OTHER;
        end
        r.obegin = s.pbegin;
        r.oclass = s.pclass;
        r.pbegin = s.tbegin;
        r.pclass = cls;
        r.mode   = MODE_IDLE;
        r.match  = TM_NONE;
        f_finish = r;
    endfunction

    // Handles a byte seen between tokens.
    function automatic t_st f_idle(input t_st s, input logic [7:0] c);
        t_st r;
        r = s;
        if (!f_is_ws(c)) begin
            if (c == CH_PCT) begin
                r.mode = MODE_COMMENT;
            end else if (c == CH_LPAREN) begin
                r.mode  = MODE_LITERAL;
                r.depth = DEPTH_BITS'(1);
            end else if (c == CH_LT) begin
                r.mode   = MODE_HEXPEND;
                r.tbegin = s.pos;
            end else if (c == CH_SLASH) begin
                r.mode   = MODE_NAME;
                r.tbegin = s.pos;
                r.match  = TM_SL;
            end else begin
                r.mode   = MODE_REGULAR;
                r.tbegin = s.pos;
                r.match  = (c == CH_B) ? TM_B : ((c == CH_E) ? TM_E : TM_OTHER);
            end
        end
        f_idle = r;
    endfunction

    always_comb begin
        logic [7:0] c;
        t_st        s;
        c   = i_in.data_byte;
        s   = r_st;
        lex = '0;
        case (s.mode)
            MODE_COMMENT: begin
                if (c == CH_LF || c == CH_CR) s.mode = MODE_IDLE;
            end
            MODE_LITERAL: begin
                if (c == CH_BSLASH) begin
                    s.mode = MODE_ESCAPE;
                end else if (c == CH_LPAREN) begin
                    s.depth = (s.depth == '1) ? s.depth : s.depth + 1'b1;
                end else if (c == CH_RPAREN) begin
                    if (s.depth <= DEPTH_BITS'(1)) begin
                        s.depth = '0;
                        s.mode  = MODE_IDLE;
                    end else begin
                        s.depth = s.depth - 1'b1;
                    end
                end
            end
            MODE_ESCAPE: begin
                s.mode = MODE_LITERAL;
            end
            MODE_HEX: begin
                if (c == CH_GT) s.mode = MODE_IDLE;
            end
            MODE_HEXPEND: begin
                if (c == CH_LT) begin
                    s.mode  = MODE_REGULAR;
                    s.match = TM_OTHER;
                end else begin
                    s.mode = (c == CH_GT) ? MODE_IDLE : MODE_HEX;
                end
            end
            MODE_NAME: begin
                if (f_is_separator(c)) begin
                    lex = f_emit(s, s.pos);
                    s   = f_idle(f_finish(s), c);
                end else if (s.match == TM_SL && c == CH_O) begin
                    s.match = TM_SL_O;
                end else if (s.match == TM_SL_O && c == CH_C) begin
                    s.match = TM_SL_OC;
                end else begin
                    s.match = TM_NAME_OTHER;
                end
            end
            MODE_REGULAR: begin
                if (f_is_ws(c) || c == CH_PCT) begin
                    lex = f_emit(s, s.pos);
                    s   = f_idle(f_finish(s), c);
                end else if (s.match == TM_B && c == CH_D) begin
                    s.match = TM_BD;
                end else if (s.match == TM_BD && c == CH_C) begin
                    s.match = TM_BDC;
                end else if (s.match == TM_E && c == CH_M) begin
                    s.match = TM_EM;
                end else if (s.match == TM_EM && c == CH_C) begin
                    s.match = TM_EMC;
                end else begin
                    s.match = TM_OTHER;
                end
            end
            default: begin
                s = f_idle(s, c);
            end
        endcase

        if (i_in.is_last) begin
            // The final byte closes any open token; only one result per byte.
            if (s.mode == MODE_NAME || s.mode == MODE_REGULAR || s.mode == MODE_HEXPEND) begin
                if (s.mode == MODE_HEXPEND) s.match = TM_OTHER;
                if (!lex.valid) lex = f_emit(s, f_sat_inc(s.pos));
            end
            n_st = ST_RESET;
        end else begin
            s.pos = f_sat_inc(s.pos);
            n_st  = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_lex = lex;

endmodule

`default_nettype wire

### rtl/pdf_layer_marker_locator.sv
// PDF layer marker locator.
// The input channel carries one content stream byte per transaction, with
// is_last set on the final byte of a stream. The output channel carries the
// byte ranges to delete: an "/OC /name BDC" group (opens_section = 1) or any
// "EMC" token (opens_section = 0), both with an exclusive end offset.
// A byte is taken into an input register, then the lexer logic updates the
// tokenizer state and loads the output register, which shows any result.
// One byte per cycle is sustained while the receiver does not stall; the
// output register separates the two channels, so a new byte is taken while
// a finished result waits. When the receiver stalls with a result pending,
// one more byte sits in the input register and then the input channel
// stalls until the result moves. After the byte that carries is_last the
// tokenizer returns to its reset state, ready for the next stream. Reset
// empties both registers and clears the tokenizer state; there is no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pdf_layer_marker_locator
    import pdfl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in     i_in,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_out
);

    logic     r_in_valid;
    t_in      r_in;
    logic     r_out_valid;
    t_result  r_out;
    logic     out_free;
    logic     step;
    t_lex_out lex;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    pdfl_lexer #(
        .OFFSET_BITS(OFFSET_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_lexer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_in   (r_in),
        .o_lex  (lex)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && lex.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && lex.valid && out_free) begin
            r_out <= lex.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### dv/pdf_layer_marker_locator_tb.sv
`timescale 1ns / 1ps

module pdf_layer_marker_locator_tb;
    import pdfl_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 4;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    byte_valid = 1'b0;
    logic    byte_stall;
    t_in     byte_item = '0;
    logic    range_valid;
    logic    range_stall = 1'b1;
    t_result range_item;

    pdf_layer_marker_locator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (byte_valid),
        .o_in_stall  (byte_stall),
        .i_in        (byte_item),
        .o_out_valid (range_valid),
        .i_out_stall (range_stall),
        .o_out       (range_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stream bytes waiting to be sent, and the delete ranges still owed by the block.
    t_in     pending_bytes[$];
    t_in     stream_buf[$];
    t_result expected_ranges[$];

    int   error_count = 0;
    int   bytes_taken = 0;
    int   quiet_cycles = 0;
    bit   byte_took = 1'b0;
    int   send_gap = 0;
    int   stall_gap = 0;
    int   hold_left = 0;
    bit   hold_req = 1'b0;
    bit   calm = 1'b0;

    // Tokenizer state of the predictor.
    t_mode       scan_mode;
    logic [15:0] scan_depth;
    logic [31:0] scan_pos;
    logic [31:0] tok_start;
    t_match      tok_kind;
    logic [31:0] prior_start;
    t_class      prior_kind;
    logic [31:0] older_start;
    t_class      older_kind;
    bit          range_emitted;

    function automatic logic [31:0] sat_next(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_name_end(input logic [7:0] c);
        return is_space(c) || c inside {CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_LBRACK,
                                        CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_SLASH, CH_PCT};
    endfunction

    task automatic reset_scanner();
        scan_mode   = MODE_IDLE;
        scan_depth  = '0;
        scan_pos    = '0;
        tok_start   = '0;
        tok_kind    = TM_NONE;
        prior_start = '0;
        prior_kind  = TC_NONE;
        older_start = '0;
        older_kind  = TC_NONE;
    endtask

    // Ends the open token; only the first token closed on a byte may yield a range.
    task automatic close_token(input logic [31:0] end_off);
        t_result r;
        t_class  cls;
        r.range_end = end_off;
        if (tok_kind == TM_BDC && older_kind == TC_OC &&
            (prior_kind == TC_OC || prior_kind == TC_NAME)) begin
            if (!range_emitted) begin
                r.range_start   = older_start;
                r.opens_section = 1'b1;
                expected_ranges.insert(expected_ranges.size(), r);
                range_emitted = 1'b1;
            end
        end else if (tok_kind == TM_EMC) begin
            if (!range_emitted) begin
                r.range_start   = tok_start;
                r.opens_section = 1'b0;
                expected_ranges.insert(expected_ranges.size(), r);
                range_emitted = 1'b1;
            end
        end
        if (tok_kind == TM_SL_OC)
            cls = TC_OC;
        else if (tok_kind inside {TM_SL, TM_SL_O, TM_SL_OC, TM_NAME_OTHER})
            cls = TC_NAME;
        else
            cls = TC_OTHER;
        older_start = prior_start;
        older_kind  = prior_kind;
        prior_start = tok_start;
        prior_kind  = cls;
        scan_mode   = MODE_IDLE;
        tok_kind    = TM_NONE;
    endtask

    task automatic start_token(input logic [7:0] c, input logic [31:0] here);
        if (is_space(c)) begin
        end else if (c == CH_PCT) begin
            scan_mode = MODE_COMMENT;
        end else if (c == CH_LPAREN) begin
            scan_mode  = MODE_LITERAL;
            scan_depth = 16'd1;
        end else if (c == CH_LT) begin
            scan_mode = MODE_HEXPEND;
            tok_start = here;
        end else if (c == CH_SLASH) begin
            scan_mode = MODE_NAME;
            tok_start = here;
            tok_kind  = TM_SL;
        end else begin
            scan_mode = MODE_REGULAR;
            tok_start = here;
            tok_kind  = (c == CH_B) ? TM_B : ((c == CH_E) ? TM_E : TM_OTHER);
        end
    endtask

    task automatic scan_stream_byte(input t_in it);
        logic [7:0]  c;
        logic [31:0] here;
        c = it.data_byte;
        here = scan_pos;
        range_emitted = 1'b0;
        case (scan_mode)
            MODE_COMMENT: begin
                if (c == CH_LF || c == CH_CR)
                    scan_mode = MODE_IDLE;
            end
            MODE_LITERAL: begin
                if (c == CH_BSLASH) begin
                    scan_mode = MODE_ESCAPE;
                end else if (c == CH_LPAREN) begin
                    if (scan_depth != '1)
                        scan_depth = scan_depth + 16'd1;
                end else if (c == CH_RPAREN) begin
                    if (scan_depth <= 16'd1) begin
                        scan_depth = '0;
                        scan_mode  = MODE_IDLE;
                    end else begin
                        scan_depth = scan_depth - 16'd1;
                    end
                end
            end
            MODE_ESCAPE: scan_mode = MODE_LITERAL;
            MODE_HEX: begin
                if (c == CH_GT)
                    scan_mode = MODE_IDLE;
            end
            MODE_HEXPEND: begin
                if (c == CH_LT) begin
                    scan_mode = MODE_REGULAR;
                    tok_kind  = TM_OTHER;
                end else begin
                    scan_mode = (c == CH_GT) ? MODE_IDLE : MODE_HEX;
                end
            end
            MODE_NAME: begin
                if (is_name_end(c)) begin
                    close_token(here);
                    start_token(c, here);
                end else if (tok_kind == TM_SL && c == CH_O) begin
                    tok_kind = TM_SL_O;
                end else if (tok_kind == TM_SL_O && c == CH_C) begin
                    tok_kind = TM_SL_OC;
                end else begin
                    tok_kind = TM_NAME_OTHER;
                end
            end
            MODE_REGULAR: begin
                if (is_space(c) || c == CH_PCT) begin
                    close_token(here);
                    start_token(c, here);
                end else if (tok_kind == TM_B && c == CH_D) begin
                    tok_kind = TM_BD;
                end else if (tok_kind == TM_BD && c == CH_C) begin
                    tok_kind = TM_BDC;
                end else if (tok_kind == TM_E && c == CH_M) begin
                    tok_kind = TM_EM;
                end else if (tok_kind == TM_EM && c == CH_C) begin
                    tok_kind = TM_EMC;
                end else begin
                    tok_kind = TM_OTHER;
                end
            end
            default: start_token(c, here);
        endcase
        if (it.is_last) begin
            if (scan_mode == MODE_NAME || scan_mode == MODE_REGULAR) begin
                close_token(sat_next(here));
            end else if (scan_mode == MODE_HEXPEND) begin
                // A lone '<' on the final byte still counts as a token.
                tok_kind = TM_OTHER;
                close_token(sat_next(here));
            end
            reset_scanner();
        end else begin
            scan_pos = sat_next(here);
        end
    endtask

    // Stimulus building.
    task automatic add_byte(input logic [7:0] c);
        t_in b;
        b.data_byte = c;
        b.is_last   = 1'b0;
        stream_buf.insert(stream_buf.size(), b);
    endtask

    task automatic add_text(input string s);
        foreach (s[i])
            add_byte(s[i]);
    endtask

    task automatic close_stream();
        if (stream_buf.size() != 0) begin
            stream_buf[$].is_last = 1'b1;
            foreach (stream_buf[i])
                pending_bytes.insert(pending_bytes.size(), stream_buf[i]);
            stream_buf.delete();
        end
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 4))
            0: return CH_O;
            1: return CH_C;
            2: return 8'h61 + 8'($urandom_range(0, 25));
            3: return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 6))
            0: return CH_B;
            1: return CH_D;
            2: return CH_C;
            3: return CH_E;
            4: return CH_M;
            5: return CH_O;
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    task automatic add_name();
        add_byte(CH_SLASH);
        repeat ($urandom_range(0, 6))
            add_byte(pick_name_char());
    endtask

    task automatic add_literal();
        int d;
        d = 1;
        add_byte(CH_LPAREN);
        repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 5))
                0: begin
                    add_byte(CH_LPAREN);
                    d++;
                end
                1: begin
                    if (d > 1) begin
                        add_byte(CH_RPAREN);
                        d--;
                    end
                end
                2: begin
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                default: add_byte(pick_word_char());
            endcase
        end
        repeat (d)
            add_byte(CH_RPAREN);
    endtask

    task automatic add_fragment();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
                add_text("/OC");
                if ($urandom_range(0, 1))
                    add_byte(pick_space());
                add_name();
                add_byte(pick_space());
                add_text("BDC");
            end
            5, 6, 7: add_text("EMC");
            8: begin
                case ($urandom_range(0, 3))
                    0: add_text("/OC BDC");
                    1: add_text("/OC /a /b BDC");
                    2: add_text("/O /a BDC");
                    default: add_text("/OCX /a BDC");
                endcase
            end
            9, 10: add_name();
            11, 12: begin
                add_byte(pick_word_char());
                repeat ($urandom_range(0, 4))
                    add_byte(pick_word_char());
            end
            13: begin
                add_byte(CH_PCT);
                repeat ($urandom_range(0, 6))
                    add_byte(8'($urandom_range(0, 255)));
                add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
            end
            14, 15: add_literal();
            16: begin
                add_byte(CH_LT);
                repeat ($urandom_range(0, 6))
                    add_byte($urandom_range(0, 3) ? 8'h30 + 8'($urandom_range(0, 9)) : CH_SPACE);
                add_byte(CH_GT);
            end
            17: begin
                case ($urandom_range(0, 2))
                    0: add_text("<<");
                    1: add_text(">>");
                    default: add_text("<>");
                endcase
            end
            18: begin
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: add_text("BD");
                    1: add_text("EM");
                    2: add_text("BDCX");
                    default: add_text("EMCE");
                endcase
            end
        endcase
        // Tokens that abut the next one without whitespace are part of the mix.
        if ($urandom_range(0, 5) != 0)
            add_byte(pick_space());
    endtask

    task automatic add_random_streams(input int n_bytes);
        int goal;
        goal = pending_bytes.size() + n_bytes;
        while (pending_bytes.size() < goal) begin
            repeat ($urandom_range(1, 30))
                add_fragment();
            close_stream();
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || byte_valid || expected_ranges.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Input side: acceptance and prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_valid && !byte_stall) begin
            scan_stream_byte(byte_item);
            void'(pending_bytes.pop_front());
            bytes_taken++;
            byte_took = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_valid <= 1'b0;
        end else if (!byte_valid || byte_took) begin
            byte_took = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                byte_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 18);
                byte_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                byte_valid <= 1'b1;
                byte_item  <= pending_bytes[0];
            end else begin
                byte_valid <= 1'b0;
            end
        end
    end

    // Output side: stall pattern and checking.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            range_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD - 1;
            range_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap--;
            range_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_gap = $urandom_range(0, 18);
            range_stall <= 1'b1;
        end else begin
            range_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : range_check
        t_result want;
        if (i_rst_n && range_valid && !range_stall) begin
            if (expected_ranges.size() == 0) begin
                $error("unexpected range: range_start=%0d range_end=%0d opens_section=%0b",
                       range_item.range_start, range_item.range_end, range_item.opens_section);
                error_count++;
            end else begin
                want = expected_ranges.pop_front();
                if (range_item.range_start !== want.range_start) begin
                    $error("range_start: expected %0d, actual %0d",
                           want.range_start, range_item.range_start);
                    error_count++;
                end
                if (range_item.range_end !== want.range_end) begin
                    $error("range_end: expected %0d, actual %0d",
                           want.range_end, range_item.range_end);
                    error_count++;
                end
                if (range_item.opens_section !== want.opens_section) begin
                    $error("opens_section: expected %0b, actual %0b",
                           want.opens_section, range_item.opens_section);
                    error_count++;
                end
            end
        end
    end

    // Ends a run in which no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_valid && !byte_stall) || (range_valid && !range_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int mark;
        reset_scanner();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Group, name ended by a slash, and an EMC closed together with a name on the last byte.
        add_text("/OC/x BDC EMC/");
        close_stream();
        add_text("EMC");
        close_stream();
        add_text("<");
        close_stream();
        add_text("(a");
        close_stream();
        add_text("%");
        close_stream();
        add_byte(8'hFF);
        add_byte(8'h00);
        close_stream();
        wait_drained();

        // Random streams; partway through, the receiver holds off long enough to
        // back the block up into its input.
        mark = bytes_taken;
        add_random_streams(500);
        while (bytes_taken < mark + 120)
            @(posedge i_clk);
        hold_req = 1'b1;
        wait_drained();

        // Nest literal strings several levels deep; the string closes after the
        // last closer and EMC follows.
        repeat (40)
            add_byte(CH_LPAREN);
        repeat (40)
            add_byte(CH_RPAREN);
        add_text(" EMC");
        close_stream();
        add_random_streams(300);
        wait_drained();

        calm = 1'b1;
        add_random_streams(200);
        wait_drained();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
